FILE: design/tdse_pkg.sv
// Types, field codes, limits and helper functions for the time/date setting editor.
`default_nettype none

package tdse_pkg;

	localparam int FIELD_COUNT = 6;

	localparam logic [2:0] FLD_HOUR   = 3'd0;
	localparam logic [2:0] FLD_MINUTE = 3'd1;
	localparam logic [2:0] FLD_SECOND = 3'd2;
	localparam logic [2:0] FLD_DAY    = 3'd3;
	localparam logic [2:0] FLD_MONTH  = 3'd4;
	localparam logic [2:0] FLD_YEAR   = 3'd5;
	localparam logic [2:0] FLD_LAST   = 3'(FIELD_COUNT - 1);

	localparam logic KIND_SCAN = 1'b0;
	localparam logic KIND_ROLL = 1'b1;

	localparam logic [6:0] HOUR_MAX   = 7'd23;
	localparam logic [6:0] MINSEC_MAX = 7'd59;
	localparam logic [6:0] DAY_MAX    = 7'd31;
	localparam logic [6:0] MONTH_MAX  = 7'd12;
	localparam logic [6:0] YEAR_MAX   = 7'd99;

	typedef struct packed {
		logic kind;
		logic next_key;
		logic up_key;
		logic down_key;
		logic done_key;
	} cmd_item_t;

	typedef struct packed {
		logic       committed;
		logic       date_advanced;
		logic [2:0] selected_field;
		logic [4:0] hour_out;
		logic [5:0] minute_out;
		logic [5:0] second_out;
		logic [4:0] day_out;
		logic [3:0] month_out;
		logic [6:0] year_out;
	} res_item_t;

	typedef struct packed {
		logic [2:0] field_ptr;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
	} clk_state_t;

	// one wrap-around step within lo..hi; below lo counts as the bottom
	function automatic logic [6:0] wrap_step(input logic [6:0] v, input logic [6:0] lo,
		input logic [6:0] hi, input logic up);
		logic [7:0] inc;
		begin
			inc = {1'b0, v} + 8'd1;
			if (up) begin
				wrap_step = (inc > {1'b0, hi}) ? lo : inc[6:0];
			end else begin
				wrap_step = (v > lo) ? (v - 7'd1) : hi;
			end
		end
	endfunction

	// year is always 0..99, so the century terms reduce to a multiple of four
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y);
		begin
			if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
				month_len = 5'd30;
			end else if (m == 4'd2) begin
				month_len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
			end else begin
				month_len = 5'd31;
			end
		end
	endfunction

endpackage

`default_nettype wire

FILE: design/tdse_keys.sv
// Button-scan next state: pointer move, commit, up/down field steps.
`default_nettype none

module tdse_keys (
	input  var tdse_pkg::clk_state_t cur,
	input  var tdse_pkg::cmd_item_t  cmd,
	output tdse_pkg::clk_state_t     nxt,
	output logic                     committed
);
	import tdse_pkg::*;

	function automatic clk_state_t step_field(input clk_state_t s, input logic up);
		clk_state_t r;
		begin
			r = s;
			unique case (s.field_ptr)
				FLD_HOUR: begin
					r.hour = 5'(wrap_step(7'(s.hour), 7'd0, HOUR_MAX, up));
				end
				FLD_MINUTE: begin
					r.minute = 6'(wrap_step(7'(s.minute), 7'd0, MINSEC_MAX, up));
				end
				FLD_SECOND: begin
					r.second = 6'(wrap_step(7'(s.second), 7'd0, MINSEC_MAX, up));
				end
				FLD_DAY: begin
					r.day = 5'(wrap_step(7'(s.day), 7'd1, DAY_MAX, up));
				end
				FLD_MONTH: begin
					r.month = 4'(wrap_step(7'(s.month), 7'd1, MONTH_MAX, up));
				end
				FLD_YEAR: begin
					r.year = wrap_step(s.year, 7'd0, YEAR_MAX, up);
				end
				default: begin
					r = s;
				end
			endcase
			step_field = r;
		end
	endfunction

	clk_state_t s;

	always_comb begin
		s = cur;
		if (cmd.next_key) begin
			s.field_ptr = (cur.field_ptr == FLD_LAST) ? FLD_HOUR : (cur.field_ptr + 3'd1);
		end
		committed = cmd.done_key;
		if (cmd.done_key) begin
			s.field_ptr = FLD_HOUR;
		end else begin
			if (cmd.up_key) begin
				s = step_field(s, 1'b1);
			end
			if (cmd.down_key) begin
				s = step_field(s, 1'b0);
			end
		end
		nxt = s;
	end

endmodule

`default_nettype wire

FILE: design/tdse_roll.sv
// End-of-day check: advances day, month and year at 23:59:59.
`default_nettype none

module tdse_roll (
	input  var tdse_pkg::clk_state_t cur,
	output tdse_pkg::clk_state_t     nxt,
	output logic                     advanced
);
	import tdse_pkg::*;

	logic [5:0] day_inc;
	logic [4:0] mlen;
	logic [3:0] month_inc;

	assign day_inc   = {1'b0, cur.day} + 6'd1;
	assign mlen      = month_len(cur.month, cur.year);
	assign month_inc = cur.month + 4'd1;

	always_comb begin
		nxt      = cur;
		advanced = 1'b0;
		if (7'(cur.hour) == HOUR_MAX && 7'(cur.minute) == MINSEC_MAX
			&& 7'(cur.second) == MINSEC_MAX) begin
			advanced = 1'b1;
			if (day_inc > {1'b0, mlen}) begin
				nxt.day = 5'd1;
				if (7'(month_inc) > MONTH_MAX) begin
					nxt.month = 4'd1;
					nxt.year  = (cur.year == YEAR_MAX) ? 7'd0 : (cur.year + 7'd1);
				end else begin
					nxt.month = month_inc;
				end
			end else begin
				nxt.day = day_inc[4:0];
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/time_date_set_editor.sv
// Top level of the time/date setting editor: item register, state and result register.
//
//   channel | dir | handshake              | payload
//   cmd     | in  | cmd_valid / cmd_stall  | kind, next_key, up_key, down_key, done_key
//   res     | out | res_valid / res_stall  | committed, date_advanced, selected_field, time/date
//
// One item per cycle while res is not stalled: the item is registered, then its result
// and the new state are computed from it and written together.
// Reset clears the state to zero with the pointer on hour; both stages empty.
// A stalled result holds; the item register still fills behind it, then cmd_stall rises.
`default_nettype none

module time_date_set_editor (
	input  var logic                clk,
	input  var logic                arst_n,
	input  var logic                cmd_valid,
	output logic                    cmd_stall,
	input  var tdse_pkg::cmd_item_t cmd,
	output logic                    res_valid,
	input  var logic                res_stall,
	output tdse_pkg::res_item_t     res
);
	import tdse_pkg::*;

	cmd_item_t  cmd_s1;
	logic       cmd_valid_s1;
	res_item_t  res_s2;
	logic       res_valid_s2;
	clk_state_t state_q;

	clk_state_t key_nxt;
	clk_state_t roll_nxt;
	clk_state_t state_n;
	logic       key_commit;
	logic       roll_adv;
	res_item_t  res_n;
	logic       out_free;
	logic       adv_s1;

	tdse_keys u_keys (
		.cur       (state_q),
		.cmd       (cmd_s1),
		.nxt       (key_nxt),
		.committed (key_commit)
	);

	tdse_roll u_roll (
		.cur      (state_q),
		.nxt      (roll_nxt),
		.advanced (roll_adv)
	);

	always_comb begin
		if (cmd_s1.kind == KIND_ROLL) begin
			state_n             = roll_nxt;
			res_n.committed     = 1'b0;
			res_n.date_advanced = roll_adv;
		end else begin
			state_n             = key_nxt;
			res_n.committed     = key_commit;
			res_n.date_advanced = 1'b0;
		end
		res_n.selected_field = state_n.field_ptr;
		res_n.hour_out       = state_n.hour;
		res_n.minute_out     = state_n.minute;
		res_n.second_out     = state_n.second;
		res_n.day_out        = state_n.day;
		res_n.month_out      = state_n.month;
		res_n.year_out       = state_n.year;
	end

	assign out_free  = !res_valid_s2 || !res_stall;
	assign adv_s1    = cmd_valid_s1 && out_free;
	assign cmd_stall = cmd_valid_s1 && !out_free;
	assign res_valid = res_valid_s2;
	assign res       = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
			res_valid_s2 <= 1'b0;
			state_q      <= '0;
		end else begin
			if (!cmd_stall) begin
				cmd_valid_s1 <= cmd_valid;
			end
			if (out_free) begin
				res_valid_s2 <= cmd_valid_s1;
			end
			if (adv_s1) begin
				state_q <= state_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
		if (adv_s1) begin
			res_s2 <= res_n;
		end
	end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the time/date setting editor: directed key table, then random edits.
`default_nettype none

module testbench;
	import tdse_pkg::*;

	localparam int DIR_N       = 24;
	localparam int RAND_ITEMS  = 600;
	localparam int N_TOTAL     = DIR_N + RAND_ITEMS;
	localparam int QUIET_TAIL  = 80;
	localparam int HOLD_CYCLES = 60;

	typedef struct packed {
		cmd_item_t stim;
		logic      typed;
		res_item_t want;
	} dir_row_t;

	// typed rows carry the readout expected after the item; the rest use the predictor
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		'{'{KIND_ROLL, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{1'b0, 1'b0, FLD_HOUR, 5'd0, 6'd0, 6'd0, 5'd0, 4'd0, 7'd0}},
		'{'{KIND_SCAN, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1,
			'{1'b0, 1'b0, FLD_HOUR, 5'd23, 6'd0, 6'd0, 5'd0, 4'd0, 7'd0}},
		'{'{KIND_SCAN, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{1'b0, 1'b0, FLD_HOUR, 5'd0, 6'd0, 6'd0, 5'd0, 4'd0, 7'd0}},
		'{'{KIND_SCAN, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1,
			'{1'b0, 1'b0, FLD_HOUR, 5'd23, 6'd0, 6'd0, 5'd0, 4'd0, 7'd0}},
		'{'{KIND_SCAN, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b1,
			'{1'b0, 1'b0, FLD_MINUTE, 5'd23, 6'd59, 6'd0, 5'd0, 4'd0, 7'd0}},
		'{'{KIND_SCAN, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b1,
			'{1'b0, 1'b0, FLD_SECOND, 5'd23, 6'd59, 6'd59, 5'd0, 4'd0, 7'd0}},
		'{'{KIND_SCAN, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b1,
			'{1'b0, 1'b0, FLD_DAY, 5'd23, 6'd59, 6'd59, 5'd31, 4'd0, 7'd0}},
		'{'{KIND_ROLL, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{KIND_ROLL, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{KIND_SCAN, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{KIND_ROLL, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0}
	};

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_item_t cmd;
	logic      res_valid;
	logic      res_stall;
	res_item_t res;

	clk_state_t calendar;
	res_item_t  expected_readouts [$];
	int         n_mismatches = 0;
	int         n_sent = 0;
	int         n_checked = 0;
	bit         quiet = 1'b0;
	bit         hold_off_req = 1'b0;

	time_date_set_editor u_top (
		.clk,
		.arst_n,
		.cmd_valid,
		.cmd_stall,
		.cmd,
		.res_valid,
		.res_stall,
		.res
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic log_mismatch(input string msg);
		n_mismatches++;
		$display("MISMATCH: %s", msg);
	endtask

	function automatic void field_range(input logic [2:0] f, output int lo, output int hi);
		lo = 0;
		case (f)
			FLD_HOUR: hi = int'(HOUR_MAX);
			FLD_DAY: begin
				lo = 1;
				hi = int'(DAY_MAX);
			end
			FLD_MONTH: begin
				lo = 1;
				hi = int'(MONTH_MAX);
			end
			FLD_YEAR: hi = int'(YEAR_MAX);
			default: hi = int'(MINSEC_MAX);
		endcase
	endfunction

	function automatic int field_value(input logic [2:0] f);
		case (f)
			FLD_HOUR:   return int'(calendar.hour);
			FLD_MINUTE: return int'(calendar.minute);
			FLD_SECOND: return int'(calendar.second);
			FLD_DAY:    return int'(calendar.day);
			FLD_MONTH:  return int'(calendar.month);
			FLD_YEAR:   return int'(calendar.year);
			default:    return 0;
		endcase
	endfunction

	// below lo counts as sitting at the bottom
	function automatic int wrap_once(input int v, input int lo, input int hi, input bit up);
		if (up) return (v + 1 > hi) ? lo : v + 1;
		return (v > lo) ? v - 1 : hi;
	endfunction

	function automatic int days_in_month(input int m, input int y);
		if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
		if (m == 2) return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
		return 31;
	endfunction

	function automatic void step_calendar_field(input bit up);
		int lo, hi, v;
		field_range(calendar.field_ptr, lo, hi);
		v = wrap_once(field_value(calendar.field_ptr), lo, hi, up);
		case (calendar.field_ptr)
			FLD_HOUR:   calendar.hour   = 5'(v);
			FLD_MINUTE: calendar.minute = 6'(v);
			FLD_SECOND: calendar.second = 6'(v);
			FLD_DAY:    calendar.day    = 5'(v);
			FLD_MONTH:  calendar.month  = 4'(v);
			FLD_YEAR:   calendar.year   = 7'(v);
			default: ;
		endcase
	endfunction

	function automatic res_item_t apply_to_calendar(input cmd_item_t c);
		res_item_t r;
		int d;
		r = '0;
		if (c.kind == KIND_SCAN) begin
			if (c.next_key) calendar.field_ptr = 3'((calendar.field_ptr + 1) % FIELD_COUNT);
			if (c.done_key) begin
				r.committed = 1'b1;
				calendar.field_ptr = FLD_HOUR;
			end else begin
				if (c.up_key) step_calendar_field(1'b1);
				if (c.down_key) step_calendar_field(1'b0);
			end
		end else if (7'(calendar.hour) == HOUR_MAX && 7'(calendar.minute) == MINSEC_MAX
				&& 7'(calendar.second) == MINSEC_MAX) begin
			r.date_advanced = 1'b1;
			d = calendar.day + 1;
			if (d > days_in_month(int'(calendar.month), int'(calendar.year))) begin
				d = 1;
				if (7'(calendar.month) >= MONTH_MAX) begin
					calendar.month = 4'd1;
					calendar.year = (calendar.year >= YEAR_MAX) ? 7'd0 : calendar.year + 7'd1;
				end else begin
					calendar.month = calendar.month + 4'd1;
				end
			end
			calendar.day = 5'(d);
		end
		r.selected_field = calendar.field_ptr;
		r.hour_out       = calendar.hour;
		r.minute_out     = calendar.minute;
		r.second_out     = calendar.second;
		r.day_out        = calendar.day;
		r.month_out      = calendar.month;
		r.year_out       = calendar.year;
		return r;
	endfunction

	task automatic cmp_field(input string name, input logic [6:0] got, input logic [6:0] want);
		if (got !== want)
			log_mismatch($sformatf("readout %0d %s: got %0d, want %0d", n_checked, name, got, want));
	endtask

	task automatic compare_readout(input res_item_t got);
		res_item_t want;
		n_checked++;
		if (expected_readouts.size() == 0) begin
			log_mismatch($sformatf("readout %0d arrived with nothing expected", n_checked));
			return;
		end
		want = expected_readouts.pop_front();
		cmp_field("committed", 7'(got.committed), 7'(want.committed));
		cmp_field("date_advanced", 7'(got.date_advanced), 7'(want.date_advanced));
		cmp_field("selected_field", 7'(got.selected_field), 7'(want.selected_field));
		cmp_field("hour", 7'(got.hour_out), 7'(want.hour_out));
		cmp_field("minute", 7'(got.minute_out), 7'(want.minute_out));
		cmp_field("second", 7'(got.second_out), 7'(want.second_out));
		cmp_field("day", 7'(got.day_out), 7'(want.day_out));
		cmp_field("month", 7'(got.month_out), 7'(want.month_out));
		cmp_field("year", got.year_out, want.year_out);
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) compare_readout(res);
	end

	// called at a falling edge; returns at a falling edge after the item is taken
	task automatic send_item(input cmd_item_t c, input bit typed = 1'b0,
		input res_item_t want = '0);
		res_item_t predicted;
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		predicted = apply_to_calendar(c);
		expected_readouts.push_back(typed ? want : predicted);
		n_sent++;
		quiet = (n_sent >= N_TOTAL - QUIET_TAIL);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	function automatic cmd_item_t scan_item(input logic nxt, input logic up, input logic dn);
		return '{KIND_SCAN, nxt, up, dn, 1'b0};
	endfunction

	function automatic cmd_item_t roll_item();
		cmd_item_t c;
		c = cmd_item_t'(5'($urandom));
		c.kind = KIND_ROLL;
		return c;
	endfunction

	function automatic int pick_target(input logic [2:0] f);
		int p;
		p = $urandom_range(0, 9);
		case (f)
			FLD_HOUR:   return (p < 5) ? int'(HOUR_MAX) : int'($urandom_range(0, HOUR_MAX));
			FLD_DAY:    return (p < 5) ? int'($urandom_range(27, DAY_MAX))
				: int'($urandom_range(1, DAY_MAX));
			FLD_MONTH: begin
				if (p < 4) return 2;
				if (p < 6) return int'(MONTH_MAX);
				return int'($urandom_range(1, MONTH_MAX));
			end
			FLD_YEAR: begin
				if (p < 3) return int'(YEAR_MAX);
				if (p < 6) return 4 * int'($urandom_range(0, 24));
				return int'($urandom_range(0, YEAR_MAX));
			end
			default:    return (p < 5) ? int'(MINSEC_MAX) : int'($urandom_range(0, MINSEC_MAX));
		endcase
	endfunction

	// walk the pointer to f, then step the shorter way round to target
	task automatic seek_field(input logic [2:0] f, input int target);
		int lo, hi, v, up_steps;
		field_range(f, lo, hi);
		while (calendar.field_ptr != f) send_item(scan_item(1'b1, 1'b0, 1'b0));
		v = field_value(f);
		while (v != target) begin
			up_steps = (target >= v) ? target - v : hi - v + target - lo + 1;
			if (2 * up_steps <= hi - lo + 1) send_item(scan_item(1'b0, 1'b1, 1'b0));
			else send_item(scan_item(1'b0, 1'b0, 1'b1));
			v = field_value(f);
		end
	endtask

	task automatic set_end_of_day();
		seek_field(FLD_HOUR, int'(HOUR_MAX));
		seek_field(FLD_MINUTE, int'(MINSEC_MAX));
		seek_field(FLD_SECOND, int'(MINSEC_MAX));
	endtask

	task automatic run_random_sequence();
		int pick;
		logic [2:0] f;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			send_item(cmd_item_t'(5'($urandom)));
		end else if (pick < 45) begin
			f = 3'($urandom_range(0, FIELD_COUNT - 1));
			seek_field(f, pick_target(f));
		end else if (pick < 60) begin
			set_end_of_day();
			repeat ($urandom_range(1, 6)) send_item(roll_item());
		end else if (pick < 70) begin
			seek_field(FLD_YEAR, pick_target(FLD_YEAR));
			seek_field(FLD_MONTH, int'(MONTH_MAX));
			seek_field(FLD_DAY, int'($urandom_range(29, DAY_MAX)));
			set_end_of_day();
			repeat ($urandom_range(1, 4)) send_item(roll_item());
		end else begin
			repeat ($urandom_range(1, 8)) send_item(roll_item());
		end
	endtask

	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				res_stall <= 1'b0;
				hold_off_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 6) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		calendar  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int i = 0; i < DIR_N; i++)
			send_item(DIR_ROWS[i].stim, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		hold_off_req = 1'b1;
		while (n_sent < N_TOTAL) run_random_sequence();
		cmd_valid <= 1'b0;
		for (int w = 0; w < 5000 && expected_readouts.size() != 0; w++) @(posedge clk);
		repeat (10) @(posedge clk);
		if (expected_readouts.size() != 0)
			log_mismatch($sformatf("%0d readouts never arrived", expected_readouts.size()));
		if (n_mismatches == 0) begin
			$display("time_date_set_editor regression: pass");
		end else begin
			$display("time_date_set_editor regression: fail");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("time_date_set_editor regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
